// ===== src/lrupr_pkg.sv =====
// Shared constants and types for the LRU page replacement block.
package lrupr_pkg;

    // Number of page frame slots held in the cell row.
    localparam int FRAMES    = 16;
    // Width of a page number.
    localparam int PAGE_BITS = 16;
    // Width of a slot index and of a recency rank.
    localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    // Width of the fill count and of the effective frame limit (0 to FRAMES).
    localparam int COUNT_W   = $clog2(FRAMES + 1);
    // Width of the frames_in_use register.
    localparam int CFG_W     = 5;
    // Width of the running fault count.
    localparam int FAULT_W   = 32;
    // Reset value of the frames_in_use register.
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(16);

    // Output tdata layout, lowest bits first: slot, evicted page, fault total.
    localparam int TDATA_USED = SLOT_W + PAGE_BITS + FAULT_W;
    localparam int M_TDATA_W  = ((TDATA_USED + 7) / 8) * 8;
    localparam int S_TDATA_W  = ((PAGE_BITS + 7) / 8) * 8;

    // Search results that ripple along the cell row.
    typedef struct packed {
        logic                 found;
        logic [SLOT_W-1:0]    hit_slot;
        logic [SLOT_W-1:0]    hit_rank;
        logic [SLOT_W-1:0]    victim_slot;
        logic [PAGE_BITS-1:0] victim_tag;
    } chain_t;

    // Update command broadcast to every cell when a transaction is taken.
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic               write_tag;
        logic [COUNT_W-1:0] old_rank;
    } upd_t;

endpackage

// ===== src/lrupr_cell.sv =====
// One frame slot: page tag, recency rank and valid bit, with its link in the search chain.
module lrupr_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lrupr_pkg::SLOT_W-1:0]    cell_idx,
    input  logic [lrupr_pkg::PAGE_BITS-1:0] page,
    input  logic [lrupr_pkg::SLOT_W-1:0]    victim_rank,
    input  lrupr_pkg::upd_t                 upd,
    input  lrupr_pkg::chain_t               chain_in,
    output lrupr_pkg::chain_t               chain_out
);
    import lrupr_pkg::*;

    logic [PAGE_BITS-1:0] tag_reg;
    logic [SLOT_W-1:0]    rank_reg;
    logic [SLOT_W-1:0]    rank_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 is_sel;
    logic                 match;
    logic                 is_victim;

    assign is_sel    = (cell_idx == upd.slot);
    assign match     = valid_reg && (tag_reg == page);
    // Ranks of the valid slots form a permutation, so the oldest is unique.
    assign is_victim = valid_reg && (rank_reg == victim_rank);

    // Merge this slot's findings into the chain from the previous cell.
    always_comb begin
        chain_out = chain_in;
        if (match) begin
            chain_out.found    = 1'b1;
            chain_out.hit_slot = cell_idx;
            chain_out.hit_rank = rank_reg;
        end
        if (is_victim) begin
            chain_out.victim_slot = cell_idx;
            chain_out.victim_tag  = tag_reg;
        end
    end

    // The touched slot becomes newest; younger valid slots age by one.
    always_comb begin
        rank_next  = rank_reg;
        valid_next = valid_reg;
        if (upd.en) begin
            if (is_sel) begin
                rank_next  = '0;
                valid_next = 1'b1;
            end else if (valid_reg && (COUNT_W'(rank_reg) < upd.old_rank)) begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            rank_reg  <= rank_next;
            valid_reg <= valid_next;
        end
    end

    // The tag is only read once the valid bit is set, so it needs no reset.
    always_ff @(posedge aclk) begin
        if (upd.en && is_sel && upd.write_tag) begin
            tag_reg <= page;
        end
    end

endmodule

// ===== src/lru_page_replacement.sv =====
// Top level of the LRU page replacement block: cell row, control and result register.
//
// Usage
//   Each transaction on the s_ channel carries one page reference in s_tdata.
//   For every reference exactly one result transaction leaves on the m_ channel:
//   m_tuser holds the hit and evicted-valid flags, m_tdata the slot now holding
//   the page, the evicted page (zero when none) and the saturating fault count.
//   Up to frames_in_use slots hold pages; a value of 0 acts as 1 and values
//   above 16 act as 16. The user must write it through cfg_wr_en / cfg_wr_data
//   only while no reference is in flight; the block itself does not enforce this.
//   The result is registered and appears in the cycle after the reference is
//   taken. Throughput is one reference per cycle while m_tready stays high, set by
//   the combinational tag search and rank update across the row of 16 slot cells.
//   Reset empties every slot, clears the fault count, sets frames_in_use to
//   16 and drops m_tvalid. When the receiver holds m_tready low, the result
//   stays in the output register and s_tready falls until it is taken.
module lru_page_replacement (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration: frames_in_use.
    input  logic                             cfg_wr_en,
    input  logic [lrupr_pkg::CFG_W-1:0]      cfg_wr_data,
    // Reference input.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: page [15:0].
    input  logic [lrupr_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result output.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: slot [3:0], evicted_page [19:4], fault_total [51:20], zero fill above.
    output logic [lrupr_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: hit [0], evicted_valid [1].
    output logic [1:0]                       m_tuser
);
    import lrupr_pkg::*;

    logic [CFG_W-1:0]     frames_in_use_reg;
    logic [COUNT_W-1:0]   filled_reg;
    logic [COUNT_W-1:0]   filled_next;
    logic [FAULT_W-1:0]   fault_reg;
    logic [FAULT_W-1:0]   fault_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    logic                 accept;
    logic [PAGE_BITS-1:0] page;
    logic [COUNT_W-1:0]   limit;
    logic [SLOT_W-1:0]    victim_rank;
    logic                 found;
    logic                 fill;
    logic                 evict;
    logic [PAGE_BITS-1:0] evicted_page;
    upd_t                 upd;
    chain_t               chain_w [FRAMES+1];

    assign page     = s_tdata[PAGE_BITS-1:0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Effective frame limit, clamped to the range 1 to FRAMES.
    always_comb begin
        if (frames_in_use_reg == '0) begin
            limit = COUNT_W'(1);
        end else if (int'(frames_in_use_reg) > FRAMES) begin
            limit = COUNT_W'(FRAMES);
        end else begin
            limit = COUNT_W'(frames_in_use_reg);
        end
    end

    // The oldest valid slot carries rank fill count minus one.
    assign victim_rank = SLOT_W'(filled_reg - 1'b1);

    // Row of slot cells; the search result ripples from cell 0 upwards.
    assign chain_w[0] = '0;

    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
        lrupr_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (SLOT_W'(i)),
            .page        (page),
            .victim_rank (victim_rank),
            .upd         (upd),
            .chain_in    (chain_w[i]),
            .chain_out   (chain_w[i+1])
        );
    end

    assign found = chain_w[FRAMES].found;
    assign fill  = !found && (filled_reg < limit);
    assign evict = !found && !fill;

    // Choose the slot to touch. On a fill or an eviction every other valid
    // slot is younger than the fill count, so all of them age.
    always_comb begin
        upd.en        = accept;
        upd.write_tag = !found;
        if (found) begin
            upd.slot     = chain_w[FRAMES].hit_slot;
            upd.old_rank = COUNT_W'(chain_w[FRAMES].hit_rank);
        end else if (fill) begin
            upd.slot     = SLOT_W'(filled_reg);
            upd.old_rank = filled_reg;
        end else begin
            upd.slot     = chain_w[FRAMES].victim_slot;
            upd.old_rank = filled_reg;
        end
    end

    assign evicted_page = evict ? chain_w[FRAMES].victim_tag : '0;

    // Fill count and saturating fault count.
    always_comb begin
        filled_next = filled_reg;
        fault_next  = fault_reg;
        if (accept && fill) begin
            filled_next = filled_reg + 1'b1;
        end
        if (accept && !found && (fault_reg != '1)) begin
            fault_next = fault_reg + 1'b1;
        end
    end

    // Output valid: set by a new result, cleared once the result is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
            filled_reg        <= '0;
            fault_reg         <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frames_in_use_reg <= cfg_wr_data;
            end
            filled_reg   <= filled_next;
            fault_reg    <= fault_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= M_TDATA_W'({fault_next, evicted_page, upd.slot});
            m_tuser_reg <= {evict, found};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== src/lrupr_checker.sv =====
// Port-level checks for the LRU page replacement block, bound to the top level.
module lrupr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lrupr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser
);
    import lrupr_pkg::*;

    // No result is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // An offered reference is taken at once while no result is waiting.
    a_take_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !m_tvalid |-> s_tready)
        else $error("reference refused with no result waiting");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A hit never evicts a page.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit reported together with an eviction");

    // Without an eviction the evicted page field reads zero.
    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata[SLOT_W+PAGE_BITS-1:SLOT_W] == '0))
        else $error("evicted page non-zero without an eviction");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/lru_page_replacement_tb.sv =====
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 100ps

module lru_page_replacement_tb;
    import lrupr_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 80;
    localparam int PRESSURE_AT  = 3;
    localparam int POOL_MAX     = 20;

    // One expected lookup outcome, field by field.
    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [FAULT_W-1:0]   fault_total;
    } lookup_t;

    // Scoreboard: keeps its own copy of the resident set and predicts each lookup.
    class lru_scoreboard;
        logic [PAGE_BITS-1:0] tag  [FRAMES];
        logic [SLOT_W-1:0]    rank [FRAMES];
        int unsigned          filled;
        logic [FAULT_W-1:0]   faults;
        logic [CFG_W-1:0]     frames_in_use;
        lookup_t              expected_lookups [$];
        int unsigned          errors;
        int unsigned          results_seen;

        function new();
            for (int i = 0; i < FRAMES; i++) begin
                tag[i]  = '0;
                rank[i] = '0;
            end
            filled        = 0;
            faults        = '0;
            frames_in_use = FRAMES_IN_USE_RESET;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function void set_frames(logic [CFG_W-1:0] value);
            frames_in_use = value;
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        // Every valid slot younger than old_rank ages by one; slot k becomes newest.
        function void refresh_slot(int k, int old_rank);
            for (int i = 0; i < filled; i++) begin
                if (i != k && int'(rank[i]) < old_rank) rank[i] = rank[i] + 1'b1;
            end
            rank[k] = '0;
        endfunction

        // Predict the outcome of one accepted page reference.
        function void note_reference(logic [PAGE_BITS-1:0] page);
            lookup_t r;
            int      limit;
            int      k;
            int      oldest;
            bit      found;
            limit = int'(frames_in_use);
            if (limit < 1) limit = 1;
            if (limit > FRAMES) limit = FRAMES;
            found = 1'b0;
            k     = 0;
            r     = '0;
            for (int i = 0; i < filled; i++) begin
                if (!found && tag[i] == page) begin
                    found = 1'b1;
                    k     = i;
                end
            end
            if (found) begin
                refresh_slot(k, int'(rank[k]));
            end else begin
                if (faults != '1) faults = faults + 1'b1;
                if (filled < limit) begin
                    // A fresh slot is older than all others, so every valid slot ages.
                    k      = filled;
                    filled = filled + 1;
                    refresh_slot(k, FRAMES + 1);
                end else begin
                    // Evict the least recently used slot; ties go to the highest index.
                    oldest = 0;
                    for (int i = 0; i < filled; i++) begin
                        if (int'(rank[i]) >= oldest) begin
                            oldest = int'(rank[i]);
                            k      = i;
                        end
                    end
                    r.evicted_valid = 1'b1;
                    r.evicted_page  = tag[k];
                    refresh_slot(k, int'(rank[k]));
                end
                tag[k] = page;
            end
            r.hit         = found;
            r.slot        = k[SLOT_W-1:0];
            r.fault_total = faults;
            expected_lookups.insert(expected_lookups.size(), r);
        endfunction

        task flag_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("mismatch at result %0d on %s: got %0h, expected %0h",
                     results_seen, what, got, want);
            errors++;
        endtask

        // Compare one accepted result with the oldest expected lookup.
        task check_result(logic [M_TDATA_W-1:0] tdata, logic [1:0] tuser);
            lookup_t want;
            if (expected_lookups.size() == 0) begin
                flag_mismatch("result with no reference outstanding", tdata, 0);
                return;
            end
            want = expected_lookups.pop_front();
            if (tuser[0] !== want.hit)
                flag_mismatch("hit", tuser[0], want.hit);
            if (tuser[1] !== want.evicted_valid)
                flag_mismatch("evicted_valid", tuser[1], want.evicted_valid);
            if (tdata[SLOT_W-1:0] !== want.slot)
                flag_mismatch("slot", tdata[SLOT_W-1:0], want.slot);
            if (tdata[SLOT_W +: PAGE_BITS] !== want.evicted_page)
                flag_mismatch("evicted_page", tdata[SLOT_W +: PAGE_BITS], want.evicted_page);
            if (tdata[SLOT_W+PAGE_BITS +: FAULT_W] !== want.fault_total)
                flag_mismatch("fault_total", tdata[SLOT_W+PAGE_BITS +: FAULT_W],
                              want.fault_total);
            results_seen++;
        endtask
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    lru_scoreboard sb;
    bit            sender_gaps   = 1'b0;
    bit            stall_on      = 1'b0;
    int            hold_requests = 0;
    int            holds_served  = 0;
    int            ready_hold    = 0;
    int            cycle_count   = 0;

    lru_page_replacement dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            m_tready     <= 1'b0;
            ready_hold   <= LONG_HOLD - 1;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor both channels; a transaction is taken where valid and ready meet.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_reference(s_tdata[PAGE_BITS-1:0]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        end
    end

    // Offer one page reference and wait until it is taken.
    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(page);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering and wait until every outstanding result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_frames(value);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0]     phase_frames [PHASES];
        logic [PAGE_BITS-1:0] pool [POOL_MAX];
        logic [PAGE_BITS-1:0] page;
        int                   limit;
        int                   pool_size;
        sb = new();
        phase_frames = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd9, 5'd12, 5'd4};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_gaps = 1'b1;
        stall_on   <= 1'b1;

        // Three frames: fill, hit, then evict the least recently used.
        write_frames(5'd3);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h0000);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0000);
        send_page(16'h5555);
        drain();

        // Limit lowered below the fill: all three slots stay filled and searchable.
        write_frames(5'd1);
        send_page(16'hAAAA);
        send_page(16'h00FF);
        send_page(16'h0000);
        drain();

        // A limit of zero behaves as one.
        write_frames(5'd0);
        send_page(16'h8001);
        send_page(16'h8001);
        send_page(16'h7FFE);
        drain();

        // A limit above the slot count behaves as the full row; the fill grows again.
        write_frames(5'd31);
        send_page(16'h0F0F);
        send_page(16'hF0F0);
        send_page(16'h3333);
        send_page(16'hCCCC);
        send_page(16'h7FFE);
        send_page(16'h0F0F);

        // Random phases: references mostly drawn from a small pool so hits and
        // evictions both occur, with some fully random pages as noise.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_frames(phase_frames[p]);
            limit = int'(phase_frames[p]);
            if (limit < 1) limit = 1;
            if (limit > FRAMES) limit = FRAMES;
            pool_size = limit + $urandom_range(0, 3);
            for (int j = 0; j < pool_size; j++) pool[j] = PAGE_BITS'($urandom);
            sender_gaps = (p != PRESSURE_AT) && (p != PHASES - 1);
            if (p == PRESSURE_AT) hold_requests = hold_requests + 1;
            if (p == PHASES - 1) stall_on <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 85)
                    page = pool[$urandom_range(0, pool_size - 1)];
                else
                    page = PAGE_BITS'($urandom);
                send_page(page);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
